/* hw/rtl/tle_pkg.sv */
// Terminal line editor: shared constants, command and status types.
// No dependencies; used by tle_ctrl, tle_dp and terminal_line_editor_top.
`timescale 1ns / 1ps

package tle_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 5;

    localparam logic [BYTE_W-1:0] CODE_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CODE_DEL     = 8'h7F;
    localparam logic [BYTE_W-1:0] CODE_BS      = 8'h08;
    localparam logic [BYTE_W-1:0] CODE_SP      = 8'h20;
    localparam logic [BYTE_W-1:0] MARKER_RESET = 8'h61;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // source of the byte loaded into the output register
    typedef enum logic [2:0] {
        SRC_BS,
        SRC_SP,
        SRC_CR,
        SRC_RX,
        SRC_STORE,
        SRC_MARK
    } t_src;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef struct packed {
        logic    accept;   // latch the incoming byte
        logic    emit;     // load the output register
        t_src    src;
        logic    last;
        logic    idx_inc;
        logic    idx_clr;
        t_cnt_op cnt_op;   // CNT_INC also writes the store
    } t_cmd;

    typedef struct packed {
        logic emit_ok;     // output register free or being emptied
        logic cnt_zero;
        logic cnt_full;
        logic idx_last;    // index points at the last held character
        logic rx_cr;
        logic rx_del;
    } t_sts;

endpackage

/* hw/rtl/tle_ctrl.sv */
// Terminal line editor sequencer: decodes each item and steps through its results.
// Depends on tle_pkg; drives tle_dp through t_cmd, reads t_sts.
`timescale 1ns / 1ps

module tle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tle_pkg::t_sts i_sts,
    output tle_pkg::t_cmd o_cmd
);
    import tle_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_BS   = 11'b000_0000_0010,
        S_SP   = 11'b000_0000_0100,
        S_CR   = 11'b000_0000_1000,
        S_LINE = 11'b000_0001_0000,
        S_MARK = 11'b000_0010_0000,
        S_DBS1 = 11'b000_0100_0000,
        S_DSP  = 11'b000_1000_0000,
        S_DBS2 = 11'b001_0000_0000,
        S_CHR  = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.src      = SRC_BS;
        o_cmd.cnt_op   = CNT_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept  = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    if (i_sts.rx_cr) begin
                        n_state = i_sts.cnt_zero ? S_CR : S_BS;
                    end else if (i_sts.rx_del) begin
                        // delete on an empty line is dropped silently
                        n_state = i_sts.cnt_zero ? S_IDLE : S_DBS1;
                    end else begin
                        n_state = i_sts.cnt_full ? S_IDLE : S_CHR;
                    end
                end
            end
            S_BS, S_SP, S_LINE: begin
                o_cmd.src = (r_state == S_BS) ? SRC_BS :
                            (r_state == S_SP) ? SRC_SP : SRC_STORE;
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = (r_state == S_BS) ? S_SP :
                                  (r_state == S_SP) ? S_CR : S_MARK;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_CR: begin
                o_cmd.src = SRC_CR;
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_sts.cnt_zero ? S_MARK : S_LINE;
                end
            end
            S_MARK: begin
                o_cmd.src  = SRC_MARK;
                o_cmd.last = 1'b1;
                if (i_sts.emit_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.cnt_op = CNT_CLR;
                    n_state      = S_IDLE;
                end
            end
            S_DBS1: begin
                o_cmd.src = SRC_BS;
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_DSP;
                end
            end
            S_DSP: begin
                o_cmd.src = SRC_SP;
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_DBS2;
                end
            end
            S_DBS2: begin
                o_cmd.src  = SRC_BS;
                o_cmd.last = 1'b1;
                if (i_sts.emit_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_IDLE;
                end
            end
            S_CHR: begin
                o_cmd.src  = SRC_RX;
                o_cmd.last = 1'b1;
                if (i_sts.emit_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tle_dp.sv */
// Terminal line editor datapath: line store, count, index, marker and output register.
// Depends on tle_pkg; commanded by tle_ctrl.
`timescale 1ns / 1ps

module tle_dp #(
    parameter int LINE_DEPTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tle_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_cfg_wr_en,
    input  logic [tle_pkg::BYTE_W-1:0]  i_cfg_wr_data,
    input  tle_pkg::t_cmd               i_cmd,
    output tle_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_out_kind,
    output logic [tle_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last
);
    import tle_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [BYTE_W-1:0] r_store [LINE_DEPTH];
    logic [BYTE_W-1:0] r_rx;
    logic [BYTE_W-1:0] r_marker;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic [CNT_W-1:0]  idx_nx;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [BYTE_W-1:0] n_byte;

    assign idx_nx = r_idx + CNT_W'(1);

    assign o_sts.emit_ok  = !r_out_valid || i_out_ready;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_full = (r_cnt == CNT_W'(LINE_DEPTH - 1));
    assign o_sts.idx_last = (idx_nx == r_cnt);
    assign o_sts.rx_cr    = (i_rx_byte == CODE_CR);
    assign o_sts.rx_del   = (i_rx_byte == CODE_DEL);

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_cnt = r_cnt + CNT_W'(1);
            CNT_DEC: n_cnt = r_cnt - CNT_W'(1);
            CNT_CLR: n_cnt = '0;
            default: n_cnt = r_cnt;
        endcase
    end

    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_nx;
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_BS:    n_byte = CODE_BS;
            SRC_SP:    n_byte = CODE_SP;
            SRC_CR:    n_byte = CODE_CR;
            SRC_RX:    n_byte = r_rx;
            SRC_STORE: n_byte = r_store[r_idx[AW-1:0]];
            SRC_MARK:  n_byte = r_marker;
            default:   n_byte = CODE_SP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_marker    <= MARKER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
            if (i_cfg_wr_en) begin
                r_marker <= i_cfg_wr_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rx <= i_rx_byte;
        end
        if (i_cmd.cnt_op == CNT_INC) begin
            r_store[r_cnt[AW-1:0]] <= r_rx;
        end
        if (i_cmd.emit) begin
            r_out_kind <= (i_cmd.src == SRC_STORE || i_cmd.src == SRC_MARK) ?
                          KIND_LINE : KIND_ECHO;
            r_out_byte <= n_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

/* hw/rtl/terminal_line_editor_top.sv */
// Terminal line editor with echo: top level joining sequencer and datapath.
// Depends on tle_pkg, tle_ctrl, tle_dp.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   in      | i_in_valid / o_in_ready   | i_rx_byte
//   out     | o_out_valid / i_out_ready | o_out_kind, o_out_byte, o_last
//   cfg     | i_cfg_wr_en (no wait)     | i_cfg_wr_data (line marker)
//
// An item is taken, then one result per cycle, while i_out_ready holds, leaves
// through the single output register: up to 59 results for a carriage return on
// a full line. Outbound stalls hold the sequence in its current state.
// The next item is taken while the final result still waits in the register.
// Reset is synchronous; count, index, marker and control clear, the store does not.
`timescale 1ns / 1ps

module terminal_line_editor_top #(
    parameter int LINE_DEPTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tle_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_out_kind,
    output logic [tle_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last,
    input  logic                        i_cfg_wr_en,
    input  logic [tle_pkg::BYTE_W-1:0]  i_cfg_wr_data
);
    import tle_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

`ifndef SYNTH
    // a result is never loaded over one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.emit_ok)
        else $error("result loaded over a pending one");

    // when ready for a new item, only a final result may still be waiting
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && o_out_valid) |-> o_last)
        else $error("sequencer idle with a non-final result pending");

    // the store never takes a character beyond capacity minus one
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cnt_op == CNT_INC) |-> !sts.cnt_full)
        else $error("line store overfilled");

    // a deleted character must exist
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cnt_op == CNT_DEC) |-> !sts.cnt_zero)
        else $error("count underflow on delete");
`endif

endmodule
